@@ rtl/core/manchester_pulse_frame_receiver_defines.svh @@
// Assertion macros shared by the frame receiver modules.
`ifndef MANCHESTER_PULSE_FRAME_RECEIVER_DEFINES_SVH
`define MANCHESTER_PULSE_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define MPFR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mpfr: assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high
`define MPFR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mpfr: assertion failed");

`endif

@@ rtl/core/mpfr_pkg.sv @@
// Types, codes and helpers of the Manchester pulse frame receiver.
package mpfr_pkg;

   // buffer status codes
   typedef enum logic [1:0] {
      STATUS_IDLE      = 2'd0,
      STATUS_WRITING   = 2'd1,
      STATUS_READING   = 2'd2,
      STATUS_AVAILABLE = 2'd3
   } status_type;

   // request kinds carried in tuser
   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_HOST = 1'b1;

   // register indexes (byte address = 8 * index)
   localparam logic [2:0] REG_SHORT_MIN   = 3'd0;
   localparam logic [2:0] REG_LONG_MIN    = 3'd1;
   localparam logic [2:0] REG_LONG_MAX    = 3'd2;
   localparam logic [2:0] REG_ENTRY_COUNT = 3'd3;
   localparam logic [2:0] REG_ID_TABLE    = 3'd4;
   localparam logic [2:0] REG_SIZE_TABLE  = 3'd5;

   // register reset values
   localparam logic [15:0] SHORT_MIN_RESET   = 16'd312;
   localparam logic [15:0] LONG_MIN_RESET    = 16'd936;
   localparam logic [15:0] LONG_MAX_RESET    = 16'd1560;
   localparam logic [3:0]  ENTRY_COUNT_RESET = 4'd1;

   typedef struct packed {
      logic [15:0] short_min_us;
      logic [15:0] long_min_us;
      logic [15:0] long_max_us;
      logic [3:0]  entry_count;
      logic [63:0] id_table;
      logic [63:0] size_table;
   } cfg_type;

   typedef struct packed {
      status_type  rx_status;
      logic        byte_valid;
      logic [8:0]  byte_index;
      logic [7:0]  byte_data;
      logic [2:0]  dataset_index;
      logic        frame_complete;
      logic        reception_aborted;
   } rsp_type;

   // pick one byte out of a packed eight-entry table
   function automatic logic [7:0] table_byte(input logic [63:0] tbl_word,
                                             input logic [2:0]  idx);
      return tbl_word[{idx, 3'b000} +: 8];
   endfunction

endpackage

@@ rtl/core/mpfr_csr.sv @@
// Configuration register file with an APB-style access port.
module mpfr_csr
   import mpfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output cfg_type     cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_sel;

   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[5:3];

   // apply a write to the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SHORT_MIN:   cfg_in.short_min_us = pwdata[15:0];
            REG_LONG_MIN:    cfg_in.long_min_us  = pwdata[15:0];
            REG_LONG_MAX:    cfg_in.long_max_us  = pwdata[15:0];
            REG_ENTRY_COUNT: cfg_in.entry_count  = pwdata[3:0];
            REG_ID_TABLE:    cfg_in.id_table     = pwdata;
            REG_SIZE_TABLE:  cfg_in.size_table   = pwdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_min_us <= SHORT_MIN_RESET;
         cfg_ff.long_min_us  <= LONG_MIN_RESET;
         cfg_ff.long_max_us  <= LONG_MAX_RESET;
         cfg_ff.entry_count  <= ENTRY_COUNT_RESET;
         cfg_ff.id_table     <= '0;
         cfg_ff.size_table   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back the addressed register
   always_comb begin
      case (reg_sel)
         REG_SHORT_MIN:   prdata = {48'd0, cfg_ff.short_min_us};
         REG_LONG_MIN:    prdata = {48'd0, cfg_ff.long_min_us};
         REG_LONG_MAX:    prdata = {48'd0, cfg_ff.long_max_us};
         REG_ENTRY_COUNT: prdata = {60'd0, cfg_ff.entry_count};
         REG_ID_TABLE:    prdata = cfg_ff.id_table;
         REG_SIZE_TABLE:  prdata = cfg_ff.size_table;
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/mpfr_decode.sv @@
// Interval classification, Manchester bit decoding and frame state.
`include "manchester_pulse_frame_receiver_defines.svh"

module mpfr_decode
   import mpfr_pkg::*;
#(
   parameter int NUM_DATASETS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic        func,
   input  logic [31:0] edge_time,
   input  logic [1:0]  status_value,
   input  cfg_type     cfg,
   output rsp_type     rsp
);

   logic [31:0] last_edge_ff, last_edge_in;
   logic        mode_ff, mode_in;
   logic [8:0]  count_ff, count_in;
   logic [7:0]  mask_ff, mask_in;
   logic [7:0]  accum_ff, accum_in;
   logic        last_bit_ff, last_bit_in;
   logic        skip_ff, skip_in;
   status_type  status_ff, status_in;
   logic [2:0]  matched_ff, matched_in;

   logic [31:0] dt;
   logic        is_long, bad_time;
   logic        bit_new;
   logic [7:0]  accum_new;
   logic [3:0]  n_use;
   logic        found;
   logic [2:0]  hit_idx;
   logic [8:0]  count_inc, size_lim;
   logic        restart, store;

   // classify the interval since the previous edge
   assign dt        = edge_time - last_edge_ff;
   assign is_long   = dt > {16'd0, cfg.long_min_us};
   assign bad_time  = (dt < {16'd0, cfg.short_min_us}) || (dt > {16'd0, cfg.long_max_us});
   assign bit_new   = last_bit_ff ^ is_long;
   assign accum_new = bit_new ? (accum_ff | mask_ff) : accum_ff;
   assign count_inc = count_ff + 9'd1;

   // clamp the table size in use
   assign n_use = (cfg.entry_count > 4'(NUM_DATASETS)) ? 4'(NUM_DATASETS)
                                                        : cfg.entry_count;

   // first table entry whose ID equals the assembled byte
   always_comb begin
      found   = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < NUM_DATASETS; i++) begin
         if (!found && (4'(i) < n_use) &&
             (table_byte(cfg.id_table, 3'(i)) == accum_new)) begin
            found   = 1'b1;
            hit_idx = 3'(i);
         end
      end
   end

   // next state and result
   always_comb begin
      last_edge_in = last_edge_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      mask_in      = mask_ff;
      accum_in     = accum_ff;
      last_bit_in  = last_bit_ff;
      skip_in      = skip_ff;
      status_in    = status_ff;
      matched_in   = matched_ff;
      restart      = 1'b0;
      store        = 1'b0;
      size_lim     = '0;
      rsp          = '0;

      if (fire) begin
         if (func == FUNC_HOST) begin
            status_in = status_type'(status_value);
         end else begin
            last_edge_in = edge_time;
            if (bad_time) begin
               restart               = 1'b1;
               rsp.reception_aborted = 1'b1;
            end else if (is_long || !skip_ff) begin
               skip_in = 1'b1;
               if (!mode_ff) begin
                  // preamble: a half-bit interval opens data mode
                  if (is_long) begin
                     restart               = 1'b1;
                     rsp.reception_aborted = 1'b1;
                  end else begin
                     mode_in = 1'b1;
                  end
               end else begin
                  last_bit_in = bit_new;
                  accum_in    = accum_new;
                  if (mask_ff[7]) begin
                     // byte complete: check the ID byte, else store
                     if (count_ff == 9'd0) begin
                        if ((status_ff == STATUS_IDLE) && found) begin
                           matched_in = hit_idx;
                           status_in  = STATUS_WRITING;
                           store      = 1'b1;
                        end else begin
                           restart               = 1'b1;
                           rsp.reception_aborted = 1'b1;
                        end
                     end else begin
                        store = 1'b1;
                     end
                     if (store) begin
                        rsp.byte_valid = 1'b1;
                        rsp.byte_index = count_ff;
                        rsp.byte_data  = accum_new;
                        mask_in        = 8'd1;
                        accum_in       = '0;
                        count_in       = count_inc;
                        size_lim       = {1'b0, table_byte(cfg.size_table, matched_in)} + 9'd2;
                        if ((count_ff != 9'd0) && (count_inc >= size_lim)) begin
                           status_in          = STATUS_AVAILABLE;
                           restart            = 1'b1;
                           rsp.frame_complete = 1'b1;
                        end
                     end
                  end else begin
                     mask_in = {mask_ff[6:0], 1'b0};
                  end
               end
            end else begin
               skip_in = 1'b0;
            end
         end

         // drop the frame in progress
         if (restart) begin
            mode_in     = 1'b0;
            count_in    = '0;
            mask_in     = 8'd1;
            accum_in    = '0;
            last_bit_in = 1'b1;
            skip_in     = 1'b1;
            if (status_in == STATUS_WRITING) begin
               status_in = STATUS_IDLE;
            end
         end
      end

      rsp.rx_status     = status_in;
      rsp.dataset_index = matched_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         mask_ff      <= 8'd1;
         accum_ff     <= '0;
         last_bit_ff  <= 1'b1;
         skip_ff      <= 1'b1;
         status_ff    <= STATUS_IDLE;
         matched_ff   <= '0;
      end else begin
         last_edge_ff <= last_edge_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         accum_ff     <= accum_in;
         last_bit_ff  <= last_bit_in;
         skip_ff      <= skip_in;
         status_ff    <= status_in;
         matched_ff   <= matched_in;
      end
   end

   `MPFR_ASSERT_IMPL(a_mask_onehot, 1'b1, $onehot(mask_ff))
   `MPFR_ASSERT_IMPL(a_idle_clean, !mode_ff, (count_ff == 9'd0) && last_bit_ff)
   `MPFR_ASSERT_NEXT(a_host_keeps_frame, fire && (func == FUNC_HOST), $stable(count_ff))

endmodule

@@ rtl/core/manchester_pulse_frame_receiver.sv @@
// Top level of the Manchester pulse frame receiver.
//
// Requests on req_* carry either a line edge (tuser 0) with its microsecond
// timestamp, or a host status write (tuser 1). Every request gives exactly
// one response on rsp_*: buffer status, the byte stored (if any) with its
// buffer position, the matched dataset entry, an abort flag, and tlast when
// the last payload byte of a frame has been stored.
// An accepted request is held in the input register, then decoded into the
// response register, which drives rsp_*. Throughput is one request per
// cycle while rsp_tready is high, set by the single decode step between the
// input register and the response register.
// If rsp_tready is low the response register holds and the input register
// takes one more request; req_tready then drops until the response is taken.
// Reset (synchronous, active high) empties both registers, returns the decoder to preamble
// search with buffer status idle and loads the register defaults. The user must write
// registers through the csr_* port only while idle; the block does not enforce this.
`include "manchester_pulse_frame_receiver_defines.svh"

module manchester_pulse_frame_receiver
   import mpfr_pkg::*;
#(
   parameter int NUM_DATASETS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // edge_time_us[31:0], status_value[33:32], zero pad
   input  logic        req_tuser,   // func
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // rx_status[1:0], byte_valid[2], byte_index[11:3],
                                    // byte_data[19:12], dataset_index[22:20],
                                    // reception_aborted[23]
   output logic        rsp_tlast,   // frame_complete
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type     cfg;
   rsp_type     dec_rsp;

   logic        in_valid_ff, in_valid_in;
   logic        in_func_ff, in_func_in;
   logic [31:0] in_time_ff, in_time_in;
   logic [1:0]  in_status_ff, in_status_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        req_take, advance;

   assign csr_pready = 1'b1;

   mpfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // advance a request when the response register is free or being emptied
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   mpfr_decode #(
      .NUM_DATASETS (NUM_DATASETS)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .func         (in_func_ff),
      .edge_time    (in_time_ff),
      .status_value (in_status_ff),
      .cfg          (cfg),
      .rsp          (dec_rsp)
   );

   // input and response register next values
   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      in_func_in   = req_take ? req_tuser : in_func_ff;
      in_time_in   = req_take ? req_tdata[31:0] : in_time_ff;
      in_status_in = req_take ? req_tdata[33:32] : in_status_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      out_in       = advance ? dec_rsp : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_func_ff   <= in_func_in;
      in_time_ff   <= in_time_in;
      in_status_ff <= in_status_in;
      out_ff       <= out_in;
   end

   // pack the response
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.frame_complete;
   assign rsp_tdata  = {out_ff.reception_aborted, out_ff.dataset_index, out_ff.byte_data,
                        out_ff.byte_index, out_ff.byte_valid, out_ff.rx_status};

   `MPFR_ASSERT_IMPL(a_done_available, out_valid_ff && out_ff.frame_complete,
                     out_ff.rx_status == STATUS_AVAILABLE)
   `MPFR_ASSERT_IMPL(a_empty_byte_zero, out_valid_ff && !out_ff.byte_valid,
                     (out_ff.byte_index == 9'd0) && (out_ff.byte_data == 8'd0))
   `MPFR_ASSERT_IMPL(a_done_not_abort, out_valid_ff,
                     !(out_ff.frame_complete && out_ff.reception_aborted))
   `MPFR_ASSERT_NEXT(a_advance_fills, advance, out_valid_ff)

endmodule
